// ----- sv/mca_pkg.sv -----
// Shared constants, types and helpers for the min-cost assignment search.
`default_nettype none
package mca_pkg;

  localparam int MAX_AGENTS  = 5;
  localparam int TARGETS     = 3;
  localparam int AGENT_W     = 3;
  localparam int TGT_W       = 2;
  localparam int COST_W      = 16;
  localparam int TOTAL_W     = 18;
  localparam int STORE_DEPTH = MAX_AGENTS * TARGETS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // stream payload widths, padded to whole bytes
  localparam int S_FIELDS_W = AGENT_W + TGT_W + COST_W;
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = AGENT_W + TOTAL_W;
  localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  typedef logic [AGENT_W-1:0] agent_t;
  typedef logic [TGT_W-1:0]   tgt_t;
  typedef logic [COST_W-1:0]  cost_t;
  typedef logic [TOTAL_W-1:0] total_t;

  localparam total_t TOTAL_ONES = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic   start;
    agent_t lim;
  } srch_req_t;

  typedef struct packed {
    logic                      done;
    total_t                    total;
    agent_t [TARGETS-1:0]      choice;
  } srch_rsp_t;

  // row-major: agent rows of TARGETS entries
  function automatic logic [ADDR_W-1:0] cost_addr(agent_t a, tgt_t t);
    return ADDR_W'(int'(a) * TARGETS + int'(t));
  endfunction

endpackage
`default_nettype wire

// ----- sv/mca_search.sv -----
// Cost store and iterative search over agent tuples with one shared adder.
`default_nettype none
module mca_search (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  mca_pkg::agent_t     wr_agent,
  input  mca_pkg::tgt_t       wr_target,
  input  mca_pkg::cost_t      wr_cost,
  input  mca_pkg::srch_req_t  req,
  output mca_pkg::srch_rsp_t  rsp
);
  import mca_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;
  localparam tgt_t LAST_PHASE = TGT_W'(TARGETS - 1);

  cost_t store [STORE_DEPTH];

  logic                 state;
  agent_t [TARGETS-1:0] pick;
  tgt_t                 phase;
  total_t               acc;
  total_t               best;
  agent_t [TARGETS-1:0] choice;
  agent_t               lim;
  logic                 done;

  agent_t               rd_agent;
  cost_t                rd_cost;
  total_t               sum;
  logic                 clash;
  agent_t [TARGETS-1:0] pick_adv;
  logic                 wrap;
  agent_t               lim_m1;
  agent_t               lim_clamped;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[cost_addr(wr_agent, wr_target)] <= wr_cost;
    end
  end

  assign rd_agent = pick[phase];
  assign rd_cost  = store[cost_addr(rd_agent, phase)];
  // phase 0 starts a fresh sum
  assign sum      = ((phase == '0) ? '0 : acc) + TOTAL_W'(rd_cost);
  assign lim_m1   = lim - AGENT_W'(1);

  always_comb begin
    clash = 1'b0;
    for (int i = 0; i < TARGETS; i++) begin
      for (int j = i + 1; j < TARGETS; j++) begin
        if (pick[i] == pick[j]) begin
          clash = 1'b1;
        end
      end
    end
  end

  // odometer step, last target digit fastest
  always_comb begin
    pick_adv = pick;
    wrap     = 1'b1;
    for (int t = TARGETS - 1; t >= 0; t--) begin
      if (wrap) begin
        if (pick[t] == lim_m1) begin
          pick_adv[t] = '0;
        end else begin
          pick_adv[t] = pick[t] + AGENT_W'(1);
          wrap        = 1'b0;
        end
      end
    end
  end

  always_comb begin
    lim_clamped = req.lim;
    if (req.lim < AGENT_W'(TARGETS)) begin
      lim_clamped = AGENT_W'(TARGETS);
    end
    if (req.lim > AGENT_W'(MAX_AGENTS)) begin
      lim_clamped = AGENT_W'(MAX_AGENTS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      best   <= TOTAL_ONES;
      choice <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            pick  <= '0;
            phase <= '0;
            best  <= TOTAL_ONES;
            lim   <= lim_clamped;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (phase == '0 && clash) begin
            pick <= pick_adv;
            done <= wrap;
            if (wrap) begin
              state <= S_IDLE;
            end
          end else if (phase == LAST_PHASE) begin
            // strict compare keeps the earliest tuple on a tie
            if (sum < best) begin
              best   <= sum;
              choice <= pick;
            end
            phase <= '0;
            pick  <= pick_adv;
            done  <= wrap;
            if (wrap) begin
              state <= S_IDLE;
            end
          end else begin
            done  <= 1'b0;
            acc   <= sum;
            phase <= phase + TGT_W'(1);
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.total  = best;
  assign rsp.choice = choice;

endmodule
`default_nettype wire

// ----- sv/min_cost_assignment_dp.sv -----
// Top level: stream ports, agent count register and result sequencing.
//
// Loads a cost matrix one entry per input transfer, then on the entry with
// tlast set searches all assignments of distinct agents to targets 0..2 and
// returns one result transfer per target, in target order.
// Input: s_axis, one cost entry per transfer; tlast starts the search.
// Entries whose agent or target index is out of range are not stored.
// A load-only transfer leaves the block idle and ready for the next entry.
// Search: one shared adder/comparator walks all agent tuples in order. A
// tuple with a repeated agent is skipped without a sum; a distinct tuple
// is summed one target at a time, in target order, and its total is then
// compared with the best total so far.
// Output: three m_axis transfers follow; tlast marks the one for target 2.
// s_axis_tready is low from the tlast transfer until the last result has
// been taken; a stalled m_axis_tready simply holds the current result.
// cfg_wr_en writes agent_count (clamped to 3..5 at search start).
// Reset: agent_count returns to 5, the block is idle and ready.
`default_nettype none
module min_cost_assignment_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // agent_index[2:0], target_index[4:3], cost[20:5], zero pad
  input  logic [mca_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // load_done
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // chosen_agent[2:0], total_cost[20:3], zero pad
  output logic [mca_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // served_target[1:0]
  output logic [mca_pkg::TGT_W-1:0]     m_axis_tuser,
  // final_flag
  output logic                          m_axis_tlast,
  input  logic                          cfg_wr_en,
  input  logic [mca_pkg::AGENT_W-1:0]   cfg_wr_data
);
  import mca_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;
  localparam tgt_t       LAST_TGT  = TGT_W'(TARGETS - 1);

  logic [1:0] state;
  tgt_t       tcnt;
  agent_t     agent_count;

  agent_t     in_agent;
  tgt_t       in_tgt;
  cost_t      in_cost;
  logic       s_fire;
  logic       m_fire;
  srch_req_t  req;
  srch_rsp_t  rsp;

  assign in_agent = s_axis_tdata[AGENT_W-1:0];
  assign in_tgt   = s_axis_tdata[AGENT_W +: TGT_W];
  assign in_cost  = s_axis_tdata[AGENT_W+TGT_W +: COST_W];

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  assign req.start = s_fire && s_axis_tlast;
  assign req.lim   = agent_count;

  mca_search u_search (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (s_fire && (in_agent < AGENT_W'(MAX_AGENTS)) && (in_tgt < TGT_W'(TARGETS))),
    .wr_agent  (in_agent),
    .wr_target (in_tgt),
    .wr_cost   (in_cost),
    .req       (req),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      agent_count <= AGENT_W'(MAX_AGENTS);
    end else if (cfg_wr_en) begin
      agent_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tcnt  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.start) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (rsp.done) begin
            tcnt  <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (m_fire) begin
            if (tcnt == LAST_TGT) begin
              state <= ST_IDLE;
            end else begin
              tcnt <= tcnt + TGT_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = (state == ST_EMIT);
  assign m_axis_tuser  = tcnt;
  assign m_axis_tlast  = (tcnt == LAST_TGT);
  assign m_axis_tdata  = M_DATA_W'({rsp.total, rsp.choice[tcnt]});

endmodule
`default_nettype wire

// ----- sv/mca_checker.sv -----
// Port-level checks for min_cost_assignment_dp, attached by bind.
`default_nettype none
module mca_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mca_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input logic [mca_pkg::TGT_W-1:0]     m_axis_tuser,
  input logic                          m_axis_tlast
);
  import mca_pkg::*;

  // no new input while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while results pending");

  // a load-only transfer never stalls the input
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=> s_axis_tready)
    else $error("input stalled after load-only transfer");

  // results step through targets without a gap
  a_next_target: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && (m_axis_tuser == TGT_W'($past(m_axis_tuser) + 1'b1))))
    else $error("result sequence broken");

  // total is the same on every result of one search
  a_total_held: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tdata[M_DATA_W-1:AGENT_W] == $past(m_axis_tdata[M_DATA_W-1:AGENT_W])))
    else $error("total changed within a search result");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind min_cost_assignment_dp mca_checker u_mca_checker (.*);
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for min_cost_assignment_dp: cost matrix loads, search results, agent count setting.
`timescale 1ns / 100ps

typedef struct packed {
  mca_pkg::tgt_t   served;
  mca_pkg::agent_t agent;
  mca_pkg::total_t total;
  logic            fin;
} assignment_t;

class min_cost_book;
  mca_pkg::cost_t  costs [mca_pkg::STORE_DEPTH];
  mca_pkg::agent_t agent_limit;
  mca_pkg::total_t best_total;
  mca_pkg::agent_t best_pick [mca_pkg::TARGETS];
  assignment_t     assignments_due [$];
  int              mismatch_count;

  function new();
    foreach (costs[i]) costs[i] = '0;
    foreach (best_pick[i]) best_pick[i] = '0;
    agent_limit    = 3'd5;
    best_total     = mca_pkg::TOTAL_ONES;
    mismatch_count = 0;
  endfunction

  function void set_agents(mca_pkg::agent_t n);
    agent_limit = n;
  endfunction

  // store one matrix entry; on the last one, run the full search
  function void take_entry(mca_pkg::agent_t a, mca_pkg::tgt_t t, mca_pkg::cost_t c, logic last);
    int n;
    int sum;
    assignment_t r;
    if (a < mca_pkg::MAX_AGENTS && t < mca_pkg::TARGETS)
      costs[int'(a) * mca_pkg::TARGETS + int'(t)] = c;
    if (!last)
      return;
    n = int'(agent_limit);
    if (n < mca_pkg::TARGETS) n = mca_pkg::TARGETS;
    if (n > mca_pkg::MAX_AGENTS) n = mca_pkg::MAX_AGENTS;
    best_total = mca_pkg::TOTAL_ONES;
    // lexicographic walk; only a strictly smaller total wins, so ties keep the earliest
    for (int a0 = 0; a0 < n; a0++) begin
      for (int a1 = 0; a1 < n; a1++) begin
        for (int a2 = 0; a2 < n; a2++) begin
          if (a0 != a1 && a0 != a2 && a1 != a2) begin
            sum = costs[a0 * mca_pkg::TARGETS] + costs[a1 * mca_pkg::TARGETS + 1]
                + costs[a2 * mca_pkg::TARGETS + 2];
            if (sum > int'(mca_pkg::TOTAL_ONES)) sum = int'(mca_pkg::TOTAL_ONES);
            if (sum < int'(best_total)) begin
              best_total   = mca_pkg::total_t'(sum);
              best_pick[0] = mca_pkg::agent_t'(a0);
              best_pick[1] = mca_pkg::agent_t'(a1);
              best_pick[2] = mca_pkg::agent_t'(a2);
            end
          end
        end
      end
    end
    for (int k = 0; k < mca_pkg::TARGETS; k++) begin
      r.served = mca_pkg::tgt_t'(k);
      r.agent  = best_pick[k];
      r.total  = best_total;
      r.fin    = (k == mca_pkg::TARGETS - 1);
      assignments_due = {assignments_due, r};
    end
  endfunction

  function void check_assignment(mca_pkg::tgt_t served, mca_pkg::agent_t agent,
                                 mca_pkg::total_t total, logic fin);
    assignment_t want;
    if (assignments_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: target %0d agent %0d total %0d last %0b",
                 served, agent, total, fin);
      return;
    end
    want = assignments_due.pop_front();
    if (served !== want.served || agent !== want.agent || total !== want.total ||
        fin !== want.fin) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch (target/agent/total/last): expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                 want.served, want.agent, want.total, want.fin, served, agent, total, fin);
    end
  endfunction

  function int pending();
    return assignments_due.size();
  endfunction
endclass

module tb;
  import mca_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RUN_ITEMS      = 30;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [TGT_W-1:0]    m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_wr_en = 1'b0;
  logic [AGENT_W-1:0]  cfg_wr_data = '0;

  min_cost_book book = new();
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int quiet_cycles   = 0;
  int agent_plan [8] = '{3, 7, 0, 4, 5, 1, 6, 2};

  min_cost_assignment_dp i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      book.check_assignment(m_axis_tuser, m_axis_tdata[AGENT_W-1:0],
                            m_axis_tdata[AGENT_W +: TOTAL_W], m_axis_tlast);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_agents(int n);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = agent_t'(n);
    book.set_agents(agent_t'(n));
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_entry(int a, int t, int c, bit last);
    @(negedge clk);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tdata  = S_DATA_W'({cost_t'(c), tgt_t'(t), agent_t'(a)});
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    book.take_entry(agent_t'(a), tgt_t'(t), cost_t'(c), last);
  endtask

  // drop valid, wait out all results, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one matrix update of random size, closed by a search request
  task automatic send_matrix_run(output int counted);
    int  len;
    int  a;
    int  t;
    int  c;
    bit  last;
    bit  bad;
    len = ($urandom_range(9) == 0) ? $urandom_range(10, 15) : $urandom_range(1, 6);
    counted = 0;
    for (int k = 0; k < len; k++) begin
      last = (k == len - 1);
      bad  = ($urandom_range(99) < (last ? 15 : 10));
      if (bad) begin
        a = $urandom_range(0, 7);
        t = $urandom_range(0, 3);
        if (a < MAX_AGENTS && t < TARGETS) a = $urandom_range(MAX_AGENTS, 7);
      end else begin
        a = $urandom_range(0, MAX_AGENTS - 1);
        t = $urandom_range(0, TARGETS - 1);
      end
      // small values force ties, all-ones pushes the totals up
      case ($urandom_range(3))
        0:       c = $urandom_range(0, 3);
        1:       c = 16'hFFFF;
        default: c = $urandom_range(0, 65535);
      endcase
      send_entry(a, t, c, last);
      if (!bad || last) counted++;
    end
  endtask

  initial begin
    int done;
    int n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // full matrix first so no entry is read before it is written
    for (int a = 0; a < MAX_AGENTS; a++)
      for (int t = 0; t < TARGETS; t++)
        send_entry(a, t, (a == 0) ? 16'hFFFF : (a * 7 + t * 3) % 11,
                   a == MAX_AGENTS - 1 && t == TARGETS - 1);
    send_entry(6, 1, 16'hFFFF, 1'b0);
    // bad target on the closing transfer: nothing stored, search still runs
    send_entry(1, 3, 0, 1'b1);
    // all-zero block over agents 0..2: tie goes to the lowest agents
    for (int a = 0; a < 3; a++)
      for (int t = 0; t < TARGETS; t++)
        send_entry(a, t, 0, a == 2 && t == TARGETS - 1);
    settle();

    for (int p = 0; p < 8; p++) begin
      write_agents(agent_plan[p]);
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 47; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 47; end
        default: begin src_idle_pct = 9; sink_stall_pct = 9; end
      endcase
      done = 0;
      while (done < RUN_ITEMS) begin
        send_matrix_run(n);
        done += n;
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatch_count == 0 && book.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
